FILE: design/assert_macros.svh
// Assertion macros used by the segmenter top-level RTL file.
// Depends on nothing; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/ccs_pkg.sv
// Package for the coalescing chunk segmenter: codes, states, constants and types.
// Used by ccs_pend_store and coalescing_chunk_segmenter_unit.
package ccs_pkg;

    localparam int NUM_CLIPBOARDS_DEF = 2;
    localparam int CHUNK_W = 17;
    localparam logic [CHUNK_W-1:0] CHUNK_SIZE_RESET = 17'd32768;
    localparam logic [CHUNK_W-1:0] CHUNK_SIZE_MAX = 17'd65536;
    localparam logic [CHUNK_W-1:0] CHUNK_SIZE_MIN = 17'd1;

    typedef enum logic [1:0] {
        ACT_SEND   = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_CANCEL = 2'd2
    } ccs_action_t;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_END   = 2'd2
    } ccs_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_PROMOTE,
        ST_DIFF,
        ST_EMIT
    } ccs_state_t;

    typedef struct packed {
        logic wr_en;
        logic push;
        logic pop;
        logic clear;
    } ccs_store_ctl_t;

endpackage

FILE: design/ccs_pend_store.sv
// Pending transfer queue of the segmenter: id, sequence and length per entry plus fill count.
// Depends on ccs_pkg for the control struct.
module ccs_pend_store #(
    parameter int NUM_CLIPBOARDS = ccs_pkg::NUM_CLIPBOARDS_DEF,
    parameter int IW = (NUM_CLIPBOARDS > 1) ? $clog2(NUM_CLIPBOARDS) : 1,
    parameter int CW = $clog2(NUM_CLIPBOARDS + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ccs_pkg::ccs_store_ctl_t ctl,
    input  logic [IW-1:0]           idx,
    input  logic [7:0]              wr_id,
    input  logic [31:0]             wr_seq,
    input  logic [31:0]             wr_len,
    output logic [7:0]              rd_id,
    output logic [7:0]              head_id,
    output logic [31:0]             head_seq,
    output logic [31:0]             head_len,
    output logic [CW-1:0]           count
);
    import ccs_pkg::*;

    logic [7:0]  id_mem  [NUM_CLIPBOARDS];
    logic [31:0] seq_mem [NUM_CLIPBOARDS];
    logic [31:0] len_mem [NUM_CLIPBOARDS];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_CLIPBOARDS; i++) begin
            if (ctl.pop && (i < NUM_CLIPBOARDS - 1)) begin
                id_mem[i]  <= id_mem[(i + 1) % NUM_CLIPBOARDS];
                seq_mem[i] <= seq_mem[(i + 1) % NUM_CLIPBOARDS];
                len_mem[i] <= len_mem[(i + 1) % NUM_CLIPBOARDS];
            end else if (ctl.wr_en && (idx == IW'(i))) begin
                id_mem[i]  <= wr_id;
                seq_mem[i] <= wr_seq;
                len_mem[i] <= wr_len;
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ctl.clear) begin
            count_next = '0;
        end else if (ctl.push) begin
            count_next = count_reg + CW'(1);
        end else if (ctl.pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign rd_id    = id_mem[idx];
    assign head_id  = id_mem[0];
    assign head_seq = seq_mem[0];
    assign head_len = len_mem[0];
    assign count    = count_reg;

endmodule

FILE: design/coalescing_chunk_segmenter_unit.sv
// Top level of the coalescing chunk segmenter: sequencer, active transfer and result register.
// Depends on ccs_pkg, ccs_pend_store and assert_macros.svh.
//
// Usage: items enter on the s_ channel (send, pacing tick, cancel) and are accepted when
// s_valid and s_ready are both high. s_ready is high only while the sequencer is idle.
// For a send, one shared id comparator walks the pending entries one per cycle before the
// entry is replaced or, when there is room, appended. A cancel, an unarmed tick or an
// ignored item is handled in the idle state. An armed tick goes through these steps:
// promote the queue head if no transfer is active, form the remaining byte count with the
// subtractor, then cut the chunk with one compare and add; its result goes to the m_
// channel. One result register sits on the m_ side, so a new item is accepted while a
// result waits; when the receiver stalls, a further tick holds in its last step until the
// register frees. The chunk_size register is written through cfg_valid and cfg_wdata,
// always ready, with zero read as 1 and values above 65536 read as 65536. Synchronous
// active-low reset empties the queue, drops the active transfer, clears the pacing flag
// and sets chunk_size to 32768; no clearing pass is needed.
module coalescing_chunk_segmenter_unit #(
    parameter int NUM_CLIPBOARDS = ccs_pkg::NUM_CLIPBOARDS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ccs_pkg::CHUNK_W-1:0]  cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_action,
    input  logic [7:0]                   s_clip_id,
    input  logic [31:0]                  s_sequence_req,
    input  logic [31:0]                  s_data_length,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_chunk_kind,
    output logic [7:0]                   m_out_clip_id,
    output logic [31:0]                  m_out_sequence,
    output logic [31:0]                  m_total_length,
    output logic [31:0]                  m_chunk_offset,
    output logic [ccs_pkg::CHUNK_W-1:0]  m_chunk_length
);
    import ccs_pkg::*;
    `include "assert_macros.svh"

    localparam int IW = (NUM_CLIPBOARDS > 1) ? $clog2(NUM_CLIPBOARDS) : 1;
    localparam int CW = $clog2(NUM_CLIPBOARDS + 1);

    ccs_state_t state_reg, state_next;
    logic [CHUNK_W-1:0] chunk_size_reg;
    logic armed_reg, armed_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [7:0]  req_id_reg, req_id_next;
    logic [31:0] req_seq_reg, req_seq_next;
    logic [31:0] req_len_reg, req_len_next;
    logic act_valid_reg, act_valid_next;
    logic act_started_reg, act_started_next;
    logic [7:0]  act_id_reg, act_id_next;
    logic [31:0] act_seq_reg, act_seq_next;
    logic [31:0] act_len_reg, act_len_next;
    logic [31:0] act_offset_reg, act_offset_next;
    logic [31:0] rest_reg, rest_next;
    logic m_valid_reg, m_valid_next;
    ccs_kind_t out_kind_reg, out_kind_next;
    logic [7:0]  out_id_reg, out_id_next;
    logic [31:0] out_seq_reg, out_seq_next;
    logic [31:0] out_total_reg, out_total_next;
    logic [31:0] out_offset_reg, out_offset_next;
    logic [CHUNK_W-1:0] out_length_reg, out_length_next;

    ccs_store_ctl_t store_ctl;
    logic [7:0]  rd_id;
    logic [7:0]  head_id;
    logic [31:0] head_seq;
    logic [31:0] head_len;
    logic [CW-1:0] pend_count;
    logic [CHUNK_W-1:0] clen;
    logic act_valid_after;

    ccs_pend_store #(
        .NUM_CLIPBOARDS(NUM_CLIPBOARDS),
        .IW(IW),
        .CW(CW)
    ) u_pend_store (
        .aclk(aclk),
        .aresetn(aresetn),
        .ctl(store_ctl),
        .idx(idx_reg[IW-1:0]),
        .wr_id(req_id_reg),
        .wr_seq(req_seq_reg),
        .wr_len(req_len_reg),
        .rd_id(rd_id),
        .head_id(head_id),
        .head_seq(head_seq),
        .head_len(head_len),
        .count(pend_count)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_size_reg <= CHUNK_SIZE_RESET;
        end else if (cfg_valid) begin
            if (cfg_wdata == '0) begin
                chunk_size_reg <= CHUNK_SIZE_MIN;
            end else if (cfg_wdata > CHUNK_SIZE_MAX) begin
                chunk_size_reg <= CHUNK_SIZE_MAX;
            end else begin
                chunk_size_reg <= cfg_wdata;
            end
        end
    end

    assign clen = (rest_reg < {15'd0, chunk_size_reg}) ? rest_reg[CHUNK_W-1:0]
                                                       : chunk_size_reg;

    always_comb begin
        state_next       = state_reg;
        armed_next       = armed_reg;
        idx_next         = idx_reg;
        req_id_next      = req_id_reg;
        req_seq_next     = req_seq_reg;
        req_len_next     = req_len_reg;
        act_valid_next   = act_valid_reg;
        act_started_next = act_started_reg;
        act_id_next      = act_id_reg;
        act_seq_next     = act_seq_reg;
        act_len_next     = act_len_reg;
        act_offset_next  = act_offset_reg;
        rest_next        = rest_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        out_kind_next    = out_kind_reg;
        out_id_next      = out_id_reg;
        out_seq_next     = out_seq_reg;
        out_total_next   = out_total_reg;
        out_offset_next  = out_offset_reg;
        out_length_next  = out_length_reg;
        store_ctl        = '0;
        act_valid_after  = act_valid_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_action)
                        ACT_SEND: begin
                            if (s_clip_id < 8'(NUM_CLIPBOARDS)) begin
                                req_id_next  = s_clip_id;
                                req_seq_next = s_sequence_req;
                                req_len_next = s_data_length;
                                idx_next     = '0;
                                state_next   = ST_SEARCH;
                            end
                        end
                        ACT_TICK: begin
                            if (armed_reg) begin
                                armed_next = 1'b0;
                                state_next = ST_PROMOTE;
                            end
                        end
                        ACT_CANCEL: begin
                            armed_next       = 1'b0;
                            act_valid_next   = 1'b0;
                            act_started_next = 1'b0;
                            act_id_next      = '0;
                            act_seq_next     = '0;
                            act_len_next     = '0;
                            act_offset_next  = '0;
                            store_ctl.clear  = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                if (idx_reg < pend_count) begin
                    if (rd_id == req_id_reg) begin
                        store_ctl.wr_en = 1'b1;
                        state_next      = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + CW'(1);
                    end
                end else begin
                    if (pend_count < CW'(NUM_CLIPBOARDS)) begin
                        store_ctl.wr_en = 1'b1;
                        store_ctl.push  = 1'b1;
                    end
                    armed_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_PROMOTE: begin
                if (!act_valid_reg && (pend_count != '0)) begin
                    act_valid_next   = 1'b1;
                    act_started_next = 1'b0;
                    act_id_next      = head_id;
                    act_seq_next     = head_seq;
                    act_len_next     = head_len;
                    act_offset_next  = '0;
                    store_ctl.pop    = 1'b1;
                end
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                if (act_valid_reg) begin
                    rest_next  = act_len_reg - act_offset_reg;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    out_id_next     = act_id_reg;
                    out_seq_next    = act_seq_reg;
                    out_total_next  = act_len_reg;
                    out_offset_next = '0;
                    out_length_next = '0;
                    if (!act_started_reg) begin
                        out_kind_next    = KIND_START;
                        act_started_next = 1'b1;
                    end else if (rest_reg != '0) begin
                        out_kind_next   = KIND_DATA;
                        out_offset_next = act_offset_reg;
                        out_length_next = clen;
                        act_offset_next = act_offset_reg + {15'd0, clen};
                    end else begin
                        out_kind_next    = KIND_END;
                        act_valid_next   = 1'b0;
                        act_started_next = 1'b0;
                        act_valid_after  = 1'b0;
                    end
                    armed_next = act_valid_after || (pend_count != '0);
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            armed_reg       <= 1'b0;
            idx_reg         <= '0;
            act_valid_reg   <= 1'b0;
            act_started_reg <= 1'b0;
            act_id_reg      <= '0;
            act_seq_reg     <= '0;
            act_len_reg     <= '0;
            act_offset_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            armed_reg       <= armed_next;
            idx_reg         <= idx_next;
            act_valid_reg   <= act_valid_next;
            act_started_reg <= act_started_next;
            act_id_reg      <= act_id_next;
            act_seq_reg     <= act_seq_next;
            act_len_reg     <= act_len_next;
            act_offset_reg  <= act_offset_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_id_reg     <= req_id_next;
        req_seq_reg    <= req_seq_next;
        req_len_reg    <= req_len_next;
        rest_reg       <= rest_next;
        out_kind_reg   <= out_kind_next;
        out_id_reg     <= out_id_next;
        out_seq_reg    <= out_seq_next;
        out_total_reg  <= out_total_next;
        out_offset_reg <= out_offset_next;
        out_length_reg <= out_length_next;
    end

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_chunk_kind   = out_kind_reg;
    assign m_out_clip_id  = out_id_reg;
    assign m_out_sequence = out_seq_reg;
    assign m_total_length = out_total_reg;
    assign m_chunk_offset = out_offset_reg;
    assign m_chunk_length = out_length_reg;

    `ASSERT_ALWAYS(a_count_max, aclk, aresetn, pend_count <= CW'(NUM_CLIPBOARDS))
    `ASSERT_ALWAYS(a_offset_in_len, aclk, aresetn, act_offset_reg <= act_len_reg)
    `ASSERT_IMPLY(a_started_active, aclk, aresetn, act_started_reg, act_valid_reg)
    `ASSERT_IMPLY(a_armed_work, aclk, aresetn, armed_reg, act_valid_reg || (pend_count != '0))
    `ASSERT_IMPLY(a_result_from_emit, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == ST_EMIT))

endmodule

FILE: dv/tb_coalescing_chunk_segmenter_unit.sv
// Self-checking testbench for coalescing_chunk_segmenter_unit: directed and random items.
// The predictor mirrors the pending queue and active transfer to form each descriptor.
// Depends on ccs_pkg and the segmenter RTL.
module tb_coalescing_chunk_segmenter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ccs_pkg::*;

    localparam int NCB = NUM_CLIPBOARDS_DEF;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int IDLE_PAUSE = 8;
    localparam int DRAIN_PAUSE = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int LIVE_PER_PHASE = 220;

    typedef struct packed {
        ccs_kind_t          kind;
        logic [7:0]         clip_id;
        logic [31:0]        seq_num;
        logic [31:0]        total_len;
        logic [31:0]        byte_off;
        logic [CHUNK_W-1:0] byte_cnt;
    } chunk_desc_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CHUNK_W-1:0] cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_action = ACT_SEND;
    logic [7:0]         s_clip_id = '0;
    logic [31:0]        s_sequence_req = '0;
    logic [31:0]        s_data_length = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_chunk_kind;
    logic [7:0]         m_out_clip_id;
    logic [31:0]        m_out_sequence;
    logic [31:0]        m_total_length;
    logic [31:0]        m_chunk_offset;
    logic [CHUNK_W-1:0] m_chunk_length;

    chunk_desc_t        chunk_expq[$];
    logic [CHUNK_W-1:0] chunk_lim;
    bit                 tick_armed;
    int                 q_cnt;
    logic [7:0]         q_id [NCB];
    logic [31:0]        q_seq [NCB];
    logic [31:0]        q_len [NCB];
    bit                 xfer_valid;
    bit                 xfer_started;
    logic [7:0]         xfer_id;
    logic [31:0]        xfer_seq;
    logic [31:0]        xfer_len;
    logic [31:0]        xfer_off;

    bit steady = 1'b0;
    int err_cnt = 0;
    int n_items = 0;
    int n_live = 0;
    int n_cfg = 0;
    int n_kind [3] = '{0, 0, 0};
    int ready_hold = 0;
    int stall_cycles = 0;

    coalescing_chunk_segmenter_unit #(
        .NUM_CLIPBOARDS(NCB)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_clip_id      (s_clip_id),
        .s_sequence_req (s_sequence_req),
        .s_data_length  (s_data_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_chunk_kind   (m_chunk_kind),
        .m_out_clip_id  (m_out_clip_id),
        .m_out_sequence (m_out_sequence),
        .m_total_length (m_total_length),
        .m_chunk_offset (m_chunk_offset),
        .m_chunk_length (m_chunk_length)
    );

    always #5 aclk = ~aclk;

    function automatic void clear_segmenter_state();
        tick_armed = 1'b0;
        xfer_valid = 1'b0;
        xfer_started = 1'b0;
        xfer_id = '0;
        xfer_seq = '0;
        xfer_len = '0;
        xfer_off = '0;
        q_cnt = 0;
    endfunction

    function automatic void segment_step(logic [1:0] act, logic [7:0] id,
                                         logic [31:0] seq, logic [31:0] len);
        chunk_desc_t d;
        logic [31:0] rest;
        bit          hit;
        hit = 1'b0;
        if (act == ACT_SEND) begin
            if (id < NCB) begin
                for (int i = 0; i < q_cnt; i++) begin
                    if (!hit && q_id[i] == id) begin
                        q_seq[i] = seq;
                        q_len[i] = len;
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    if (q_cnt < NCB) begin
                        q_id[q_cnt] = id;
                        q_seq[q_cnt] = seq;
                        q_len[q_cnt] = len;
                        q_cnt++;
                    end
                    tick_armed = 1'b1;
                end
            end
        end else if (act == ACT_TICK) begin
            if (tick_armed) begin
                tick_armed = 1'b0;
                if (!xfer_valid && q_cnt > 0) begin
                    xfer_valid = 1'b1;
                    xfer_started = 1'b0;
                    xfer_id = q_id[0];
                    xfer_seq = q_seq[0];
                    xfer_len = q_len[0];
                    xfer_off = '0;
                    for (int i = 1; i < q_cnt; i++) begin
                        q_id[i-1] = q_id[i];
                        q_seq[i-1] = q_seq[i];
                        q_len[i-1] = q_len[i];
                    end
                    q_cnt--;
                end
                if (xfer_valid) begin
                    d.clip_id = xfer_id;
                    d.seq_num = xfer_seq;
                    d.total_len = xfer_len;
                    d.byte_off = '0;
                    d.byte_cnt = '0;
                    if (!xfer_started) begin
                        d.kind = KIND_START;
                        xfer_started = 1'b1;
                    end else if (xfer_off < xfer_len) begin
                        rest = xfer_len - xfer_off;
                        d.kind = KIND_DATA;
                        d.byte_off = xfer_off;
                        d.byte_cnt = (rest < 32'(chunk_lim)) ? rest[CHUNK_W-1:0] : chunk_lim;
                        xfer_off = xfer_off + 32'(d.byte_cnt);
                    end else begin
                        d.kind = KIND_END;
                        xfer_valid = 1'b0;
                        xfer_started = 1'b0;
                    end
                    chunk_expq.insert(chunk_expq.size(), d);
                    tick_armed = xfer_valid || q_cnt > 0;
                end
            end
        end else if (act == ACT_CANCEL) begin
            clear_segmenter_state();
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_id();
        if ($urandom_range(0, 99) < 88) return 8'($urandom_range(0, NCB - 1));
        return 8'($urandom_range(NCB, 255));
    endfunction

    function automatic logic [31:0] pick_len();
        int r;
        int lim;
        lim = chunk_lim;
        r = $urandom_range(0, 99);
        if (r < 10) return 0;
        if (r < 75) return $urandom_range(1, 5 * lim);
        if (r < 90) return $urandom_range(lim - 1, lim + 1);
        return $urandom;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        err_cnt++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h (error %0d)",
                 $realtime, what, got, want, err_cnt);
    endtask

    task automatic send_item(logic [1:0] act, logic [7:0] id,
                             logic [31:0] seq, logic [31:0] len);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_clip_id <= id;
        s_sequence_req <= seq;
        s_data_length <= len;
        do @(posedge aclk); while (!s_ready);
        n_items++;
        if (act != ACT_UNUSED && !(act == ACT_SEND && id >= NCB)) n_live++;
        segment_step(act, id, seq, len);
    endtask

    task automatic write_chunk_size(logic [CHUNK_W-1:0] value);
        s_valid <= 1'b0;
        while (chunk_expq.size() != 0) @(posedge aclk);
        repeat (IDLE_PAUSE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_cfg++;
        if (value == '0) chunk_lim = CHUNK_SIZE_MIN;
        else if (value > CHUNK_SIZE_MAX) chunk_lim = CHUNK_SIZE_MAX;
        else chunk_lim = value;
    endtask

    task automatic test_ignored_items();
        send_item(ACT_UNUSED, 8'hFF, '1, '1);
        send_item(ACT_SEND, 8'hFF, '1, '1);
        send_item(ACT_SEND, 8'(NCB), 32'h0, 32'h10);
        send_item(ACT_TICK, 8'h00, '0, '0);
        send_item(ACT_CANCEL, 8'hFF, '1, '1);
    endtask

    task automatic test_empty_snapshot();
        send_item(ACT_SEND, 8'd0, 32'h0, 32'h0);
        repeat (3) send_item(ACT_TICK, 8'd0, '0, '0);
    endtask

    task automatic test_coalescing();
        send_item(ACT_SEND, 8'd1, 32'h1111_0001, 32'd5);
        send_item(ACT_SEND, 8'd0, 32'h2222_0002, 32'd3);
        send_item(ACT_SEND, 8'd1, 32'h3333_0003, 32'd7);
        repeat (6) send_item(ACT_TICK, 8'd0, '0, '0);
    endtask

    task automatic test_chunk_size_limits();
        write_chunk_size(17'd0);
        send_item(ACT_SEND, 8'd1, 32'h0, 32'd2);
        repeat (4) send_item(ACT_TICK, 8'd1, '0, '0);
        write_chunk_size(17'h1FFFF);
        send_item(ACT_SEND, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (3) send_item(ACT_TICK, 8'd0, '0, '0);
        send_item(ACT_CANCEL, 8'd0, '0, '0);
    endtask

    task automatic run_transfer_burst();
        int ticks;
        repeat ($urandom_range(1, 3)) send_item(ACT_SEND, pick_id(), $urandom, pick_len());
        ticks = 0;
        while (tick_armed && ticks < 40) begin
            if ($urandom_range(0, 11) == 0) begin
                send_item(ACT_SEND, pick_id(), $urandom, pick_len());
            end
            send_item(ACT_TICK, 8'($urandom), $urandom, $urandom);
            ticks++;
        end
        case ($urandom_range(0, 3))
            0: begin
                send_item(ACT_CANCEL, 8'($urandom), $urandom, $urandom);
            end
            1: begin
                send_item(ACT_TICK, 8'($urandom), $urandom, $urandom);
            end
            default: begin
            end
        endcase
    endtask

    task automatic test_random_traffic();
        logic [CHUNK_W-1:0] settings [8];
        int goal;
        settings = '{17'd1, 17'd3, 17'd0, 17'd65536, 17'h1FFFF, 17'd32768, 17'd0, 17'd0};
        settings[6] = CHUNK_W'($urandom_range(1, 64));
        settings[7] = CHUNK_W'($urandom);
        for (int p = 0; p < 8; p++) begin
            write_chunk_size(settings[p]);
            steady = (p == 3);
            goal = n_live + LIVE_PER_PHASE;
            while (n_live < goal) begin
                if ($urandom_range(0, 99) < 75) begin
                    run_transfer_burst();
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        send_item(2'($urandom_range(0, 3)), 8'($urandom), $urandom, $urandom);
                    end
                end
            end
        end
        steady = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (steady) begin
            m_ready <= 1'b1;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (m_ready) begin
            ready_hold <= pick_gap();
            m_ready <= 1'b0;
        end else begin
            ready_hold <= $urandom_range(0, 7);
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        chunk_desc_t want;
        if (aresetn && m_valid && m_ready) begin
            if (m_chunk_kind < 3) n_kind[m_chunk_kind]++;
            if (chunk_expq.size() == 0) begin
                report_mismatch("unexpected item", 32'(m_chunk_kind), 32'h0);
            end else begin
                want = chunk_expq[0];
                chunk_expq.delete(0);
                if (m_chunk_kind !== want.kind)
                    report_mismatch("chunk_kind", 32'(m_chunk_kind), 32'(want.kind));
                if (m_out_clip_id !== want.clip_id)
                    report_mismatch("out_clip_id", 32'(m_out_clip_id), 32'(want.clip_id));
                if (m_out_sequence !== want.seq_num)
                    report_mismatch("out_sequence", m_out_sequence, want.seq_num);
                if (m_total_length !== want.total_len)
                    report_mismatch("total_length", m_total_length, want.total_len);
                if (m_chunk_offset !== want.byte_off)
                    report_mismatch("chunk_offset", m_chunk_offset, want.byte_off);
                if (m_chunk_length !== want.byte_cnt)
                    report_mismatch("chunk_length", 32'(m_chunk_length), 32'(want.byte_cnt));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d cycles without an accepted item", stall_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        chunk_lim = CHUNK_SIZE_RESET;
        clear_segmenter_state();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_ignored_items();
        test_empty_snapshot();
        test_coalescing();
        test_chunk_size_limits();
        test_random_traffic();
        s_valid <= 1'b0;
        while (chunk_expq.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAUSE) @(posedge aclk);
        $display("Sent %0d items (%0d not ignored) over %0d chunk size settings.",
                 n_items, n_live, n_cfg);
        $display("Checked %0d start, %0d data and %0d end descriptors, %0d errors.",
                 n_kind[0], n_kind[1], n_kind[2], err_cnt);
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

FILE: coalescing_chunk_segmenter_unit.f
+incdir+design
design/ccs_pkg.sv
design/ccs_pend_store.sv
design/coalescing_chunk_segmenter_unit.sv
dv/tb_coalescing_chunk_segmenter_unit.sv
